FILE: hw/rtl/csc_pkg.sv
// csc_pkg: shared types, constants and a saturation helper for the cloth spring step block
// used by cloth_spring_constraint_step and its port checker; no dependencies
package csc_pkg;

  localparam int FRAC_BITS  = 16;   // position and stiffness fraction bits
  localparam int RATIO_FRAC = 16;   // stretch ratio fraction bits
  localparam int DT_FRAC    = 16;   // time step fraction bits
  localparam int UNIT_FRAC  = 30;   // unit vector fraction bits

  localparam logic [9:0]  IMPULSE_GAIN = 10'd1000;
  localparam logic [30:0] SQRT2_Q30    = 31'd1518500250;

  localparam int ROOT_W   = 34;           // root of a sum of three squared 33-bit values
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 3;
  localparam int QUOT_W   = UNIT_FRAC + 1; // unit component is at most 1.0
  localparam int LIMIT_W  = 40;
  localparam int DELTA_W  = 42;
  localparam int M1_W     = 50;
  localparam int M2_W     = 60;
  localparam int M3_W     = 60;

  localparam logic [31:0] STIFFNESS_RESET = 32'(10 << FRAC_BITS);
  localparam logic [23:0] STRETCH_RESET   = 24'd72090;

  localparam logic [0:0] REG_STIFFNESS   = 1'b0;
  localparam logic [0:0] REG_MAX_STRETCH = 1'b1;

  typedef struct packed {
    logic [31:0] pos_a_x;
    logic [31:0] pos_a_y;
    logic [31:0] pos_a_z;
    logic [31:0] pos_b_x;
    logic [31:0] pos_b_y;
    logic [31:0] pos_b_z;
    logic        fixed_a;
    logic        fixed_b;
    logic [30:0] rest_length;
    logic        is_diagonal;
    logic [15:0] time_step;
  } spring_t;

  typedef struct packed {
    logic [31:0] impulse_a_x;
    logic [31:0] impulse_a_y;
    logic [31:0] impulse_a_z;
    logic [31:0] new_a_x;
    logic [31:0] new_a_y;
    logic [31:0] new_a_z;
    logic [31:0] new_b_x;
    logic [31:0] new_b_y;
    logic [31:0] new_b_z;
    logic        moved_a;
    logic        moved_b;
  } result_t;

  // per-spring context carried down the pipeline
  typedef struct packed {
    logic [2:0][31:0]      pa;
    logic [2:0][31:0]      pb;
    logic [2:0][32:0]      dm;
    logic [2:0]            dneg;
    logic                  fa;
    logic                  fb;
    logic [31:0]           offset;
    logic [LIMIT_W-1:0]    limit;
    logic [15:0]           dt;
  } ctx_t;

  function automatic logic [31:0] sat32(input logic signed [43:0] v);
    logic [31:0] r;
    if (v > $signed(44'h0007FFFFFFF)) r = 32'h7FFF_FFFF;
    else if (v < $signed(44'hFFF80000000)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/cloth_spring_constraint_step.sv
// cloth_spring_constraint_step: hooke impulse and max-stretch correction per spring
// depends on csc_pkg for the item types, register codes and saturation helper
//
// One spring enters and one result leaves per cycle unless the output stalls; its stages are
// the bit-per-stage square root (34 stages), the three bit-per-stage unit vector dividers
// (31 stages), three front stages, one divider setup stage and six multiply stages. The whole
// pipeline advances together: while a result sits at the output unaccepted, spring_ready is
// low and every stage holds, so nothing is lost or repeated. Configuration writes take effect
// at once and should only be made while the pipeline is empty.
module cloth_spring_constraint_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             spring_valid,
  output logic             spring_ready,
  input  csc_pkg::spring_t spring,
  output logic             result_valid,
  input  logic             result_ready,
  output csc_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic [61:0] DIAG_ROUND  = 62'd1 << (csc_pkg::UNIT_FRAC - 1);
  localparam logic [55:0] RATIO_ROUND = 56'd1 << (csc_pkg::RATIO_FRAC - 1);
  localparam logic [71:0] DELTA_ROUND = 72'd1 << (csc_pkg::UNIT_FRAC - 1);

  // configuration registers
  logic [31:0] stiffness;
  logic [23:0] max_stretch_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness         <= csc_pkg::STIFFNESS_RESET;
      max_stretch_ratio <= csc_pkg::STRETCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csc_pkg::REG_STIFFNESS:   stiffness <= cfg_data;
        csc_pkg::REG_MAX_STRETCH: max_stretch_ratio <= cfg_data[23:0];
        default:                  stiffness <= stiffness;
      endcase
    end
  end

  // global advance: every stage moves when the output register is free or being taken
  logic adv;
  assign adv          = !result_valid || result_ready;
  assign spring_ready = adv;

  // ---------------------------------------------------------------------------
  // stage 0: differences, magnitudes, effective rest length
  // ---------------------------------------------------------------------------
  csc_pkg::ctx_t s0_ctx_next, s0_ctx;
  logic          s0_v;
  logic [61:0]   diag_prod;
  logic signed [32:0] dd [3];

  always_comb begin
    s0_ctx_next       = '0;
    s0_ctx_next.pa[0] = spring.pos_a_x;
    s0_ctx_next.pa[1] = spring.pos_a_y;
    s0_ctx_next.pa[2] = spring.pos_a_z;
    s0_ctx_next.pb[0] = spring.pos_b_x;
    s0_ctx_next.pb[1] = spring.pos_b_y;
    s0_ctx_next.pb[2] = spring.pos_b_z;
    for (int i = 0; i < 3; i++) begin
      dd[i] = $signed({s0_ctx_next.pb[i][31], s0_ctx_next.pb[i]})
            - $signed({s0_ctx_next.pa[i][31], s0_ctx_next.pa[i]});
      s0_ctx_next.dneg[i] = dd[i][32];
      s0_ctx_next.dm[i]   = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
    end
    s0_ctx_next.fa = spring.fixed_a;
    s0_ctx_next.fb = spring.fixed_b;
    s0_ctx_next.dt = spring.time_step;
    diag_prod = 62'(spring.rest_length) * 62'(csc_pkg::SQRT2_Q30);
    // diagonal rest length is rounded to nearest
    s0_ctx_next.offset = spring.is_diagonal ?
        32'((diag_prod + DIAG_ROUND) >> csc_pkg::UNIT_FRAC) : {1'b0, spring.rest_length};
  end

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (adv) s0_v <= spring_valid;
    if (adv) s0_ctx <= s0_ctx_next;
  end

  // ---------------------------------------------------------------------------
  // stage 1: squares and stretch limit
  // ---------------------------------------------------------------------------
  csc_pkg::ctx_t    s1_ctx_next, s1_ctx;
  logic             s1_v;
  logic [2:0][64:0] s1_sq;
  logic [55:0]      limit_prod;

  assign limit_prod = 56'(s0_ctx.offset) * 56'(max_stretch_ratio);

  always_comb begin
    s1_ctx_next       = s0_ctx;
    s1_ctx_next.limit = csc_pkg::LIMIT_W'((limit_prod + RATIO_ROUND) >> csc_pkg::RATIO_FRAC);
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= s0_v;
    if (adv) begin
      s1_ctx <= s1_ctx_next;
      for (int i = 0; i < 3; i++) s1_sq[i] <= 65'(s0_ctx.dm[i]) * 65'(s0_ctx.dm[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // square root, one root bit per stage; entry 0 holds the summed squares
  // ---------------------------------------------------------------------------
  csc_pkg::ctx_t                  sq_ctx  [csc_pkg::ROOT_W+1];
  logic                           sq_v    [csc_pkg::ROOT_W+1];
  logic [csc_pkg::SQ_REM_W-1:0]   sq_rem  [csc_pkg::ROOT_W+1];
  logic [csc_pkg::ROOT_W-1:0]     sq_root [csc_pkg::ROOT_W+1];
  logic [csc_pkg::RAD_W-1:0]      sq_rad  [csc_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= s1_v;
    if (adv) begin
      sq_ctx[0]  <= s1_ctx;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_rad[0]  <= csc_pkg::RAD_W'(67'(s1_sq[0]) + 67'(s1_sq[1]) + 67'(s1_sq[2]));
    end
  end

  for (genvar k = 0; k < csc_pkg::ROOT_W; k++) begin : g_sqrt
    logic [csc_pkg::SQ_REM_W-1:0] cur;
    logic [csc_pkg::SQ_REM_W-1:0] trial;
    logic                         ge;

    // remainder stays below 2^35, so its top bits are dropped on the shift
    assign cur   = {sq_rem[k][csc_pkg::SQ_REM_W-3:0], sq_rad[k][csc_pkg::RAD_W-1 -: 2]};
    assign trial = {1'b0, sq_root[k], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
      if (adv) begin
        sq_ctx[k+1]  <= sq_ctx[k];
        sq_rem[k+1]  <= ge ? cur - trial : cur;
        sq_root[k+1] <= {sq_root[k][csc_pkg::ROOT_W-2:0], ge};
        sq_rad[k+1]  <= {sq_rad[k][csc_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // unit vector: three restoring dividers, one quotient bit per stage
  // ---------------------------------------------------------------------------
  csc_pkg::ctx_t                   dv_ctx [csc_pkg::QUOT_W+1];
  logic                            dv_v   [csc_pkg::QUOT_W+1];
  logic [csc_pkg::ROOT_W-1:0]      dv_len [csc_pkg::QUOT_W+1];
  logic [2:0][csc_pkg::ROOT_W-1:0] dv_rem [csc_pkg::QUOT_W+1];
  logic [2:0][csc_pkg::QUOT_W-1:0] dv_q   [csc_pkg::QUOT_W+1];

  // each component is no longer than the length, so half of it is a valid first remainder
  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= sq_v[csc_pkg::ROOT_W];
    if (adv) begin
      dv_ctx[0] <= sq_ctx[csc_pkg::ROOT_W];
      dv_len[0] <= sq_root[csc_pkg::ROOT_W];
      dv_q[0]   <= '0;
      for (int i = 0; i < 3; i++)
        dv_rem[0][i] <= csc_pkg::ROOT_W'(sq_ctx[csc_pkg::ROOT_W].dm[i] >> 1);
    end
  end

  for (genvar j = 0; j < csc_pkg::QUOT_W; j++) begin : g_div
    logic [2:0][csc_pkg::ROOT_W:0]   cur;
    logic [2:0]                      ge;
    logic [2:0][csc_pkg::ROOT_W-1:0] rem_next;
    logic [2:0]                      din;

    for (genvar i = 0; i < 3; i++) begin : g_lane
      // dividend is the component shifted up: its lowest bit, then zeros
      assign din[i]      = (j == 0) ? dv_ctx[j].dm[i][0] : 1'b0;
      assign cur[i]      = {dv_rem[j][i], din[i]};
      assign ge[i]       = cur[i] >= {1'b0, dv_len[j]};
      assign rem_next[i] = ge[i] ? csc_pkg::ROOT_W'(cur[i] - {1'b0, dv_len[j]})
                                 : csc_pkg::ROOT_W'(cur[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else if (adv) dv_v[j+1] <= dv_v[j];
      if (adv) begin
        dv_ctx[j+1] <= dv_ctx[j];
        dv_len[j+1] <= dv_len[j];
        dv_rem[j+1] <= rem_next;
        for (int i = 0; i < 3; i++)
          dv_q[j+1][i] <= {dv_q[j][i][csc_pkg::QUOT_W-2:0], ge[i]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // e1: stretch, limit test, correction distance partial products
  // ---------------------------------------------------------------------------
  csc_pkg::ctx_t                   e1_ctx;
  logic                            e1_v;
  logic [2:0][csc_pkg::QUOT_W-1:0] e1_u;
  logic                            e1_sneg;
  logic [33:0]                     e1_smag;
  logic                            e1_move;
  logic [2:0][62:0]                e1_plo;
  logic [2:0][38:0]                e1_phi;

  logic [csc_pkg::ROOT_W-1:0]      len;
  logic                            len_zero;
  logic signed [34:0]              stretch;
  logic [2:0][csc_pkg::QUOT_W-1:0] unit;

  assign len      = dv_len[csc_pkg::QUOT_W];
  assign len_zero = len == '0;
  assign stretch  = $signed({1'b0, len}) - $signed({3'b000, dv_ctx[csc_pkg::QUOT_W].offset});

  // zero-length spring: no direction, so no impulse and no correction
  always_comb begin
    for (int i = 0; i < 3; i++) unit[i] = len_zero ? '0 : dv_q[csc_pkg::QUOT_W][i];
  end

  always_ff @(posedge clk) begin
    if (rst) e1_v <= 1'b0;
    else if (adv) e1_v <= dv_v[csc_pkg::QUOT_W];
    if (adv) begin
      e1_ctx  <= dv_ctx[csc_pkg::QUOT_W];
      e1_u    <= unit;
      e1_sneg <= stretch[34];
      e1_smag <= stretch[34] ? 34'(-stretch) : 34'(stretch);
      e1_move <= (csc_pkg::LIMIT_W'(len) > dv_ctx[csc_pkg::QUOT_W].limit)
              && !(dv_ctx[csc_pkg::QUOT_W].fa && dv_ctx[csc_pkg::QUOT_W].fb);
      for (int i = 0; i < 3; i++) begin
        e1_plo[i] <= 63'(unit[i]) * 63'(dv_ctx[csc_pkg::QUOT_W].limit[31:0]);
        e1_phi[i] <= 39'(unit[i]) * 39'(dv_ctx[csc_pkg::QUOT_W].limit[39:32]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // e2: spring force term and correction distance per axis
  // ---------------------------------------------------------------------------
  csc_pkg::ctx_t                    e2_ctx;
  logic                             e2_v;
  logic [2:0][csc_pkg::QUOT_W-1:0]  e2_u;
  logic                             e2_sneg;
  logic                             e2_move;
  logic [csc_pkg::M1_W-1:0]         e2_m1;
  logic [2:0][csc_pkg::DELTA_W-1:0] e2_delta;
  logic [65:0]                      force_prod;

  assign force_prod = 66'(stiffness) * 66'(e1_smag);

  always_ff @(posedge clk) begin
    if (rst) e2_v <= 1'b0;
    else if (adv) e2_v <= e1_v;
    if (adv) begin
      e2_ctx  <= e1_ctx;
      e2_u    <= e1_u;
      e2_sneg <= e1_sneg;
      e2_move <= e1_move;
      e2_m1   <= csc_pkg::M1_W'(force_prod >> csc_pkg::FRAC_BITS);
      for (int i = 0; i < 3; i++)
        e2_delta[i] <= csc_pkg::DELTA_W'((72'(e1_plo[i]) + (72'(e1_phi[i]) << 32)
                                          + DELTA_ROUND) >> csc_pkg::UNIT_FRAC);
    end
  end

  // ---------------------------------------------------------------------------
  // e3: gain of 1000, corrected positions
  // ---------------------------------------------------------------------------
  logic                            e3_v;
  logic [2:0][csc_pkg::QUOT_W-1:0] e3_u;
  logic                            e3_sneg;
  logic [2:0]                      e3_dneg;
  logic [15:0]                     e3_dt;
  logic [csc_pkg::M2_W-1:0]        e3_m2;
  logic [2:0][31:0]                e3_na;
  logic [2:0][31:0]                e3_nb;
  logic                            e3_moved_a;
  logic                            e3_moved_b;

  logic [2:0][31:0]   na_next;
  logic [2:0][31:0]   nb_next;
  logic signed [43:0] pa_w [3];
  logic signed [43:0] pb_w [3];
  logic signed [43:0] sd   [3];
  logic signed [43:0] sh   [3];
  logic [32:0]        half [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_w[i] = $signed({{12{e2_ctx.pa[i][31]}}, e2_ctx.pa[i]});
      pb_w[i] = $signed({{12{e2_ctx.pb[i][31]}}, e2_ctx.pb[i]});
      sd[i]   = e2_ctx.dneg[i] ? -$signed(44'(e2_delta[i])) : $signed(44'(e2_delta[i]));
      // symmetric case: half the excess, rounded toward zero
      half[i] = (csc_pkg::DELTA_W'(e2_ctx.dm[i]) >= e2_delta[i]) ?
                33'((csc_pkg::DELTA_W'(e2_ctx.dm[i]) - e2_delta[i]) >> 1) : '0;
      sh[i]   = e2_ctx.dneg[i] ? -$signed(44'(half[i])) : $signed(44'(half[i]));
      na_next[i] = e2_ctx.pa[i];
      nb_next[i] = e2_ctx.pb[i];
      if (e2_move) begin
        if (e2_ctx.fa) begin
          nb_next[i] = csc_pkg::sat32(pa_w[i] + sd[i]);
        end else if (e2_ctx.fb) begin
          na_next[i] = csc_pkg::sat32(pb_w[i] - sd[i]);
        end else begin
          na_next[i] = csc_pkg::sat32(pa_w[i] + sh[i]);
          nb_next[i] = csc_pkg::sat32(pb_w[i] - sh[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e3_v <= 1'b0;
    else if (adv) e3_v <= e2_v;
    if (adv) begin
      e3_u       <= e2_u;
      e3_sneg    <= e2_sneg;
      e3_dneg    <= e2_ctx.dneg;
      e3_dt      <= e2_ctx.dt;
      e3_m2      <= csc_pkg::M2_W'(e2_m1) * csc_pkg::M2_W'(csc_pkg::IMPULSE_GAIN);
      e3_na      <= na_next;
      e3_nb      <= nb_next;
      e3_moved_a <= e2_move && !e2_ctx.fa;
      e3_moved_b <= e2_move && !e2_ctx.fb;
    end
  end

  // ---------------------------------------------------------------------------
  // e4: scale by time step
  // ---------------------------------------------------------------------------
  logic                            e4_v;
  logic [2:0][csc_pkg::QUOT_W-1:0] e4_u;
  logic                            e4_sneg;
  logic [2:0]                      e4_dneg;
  logic [csc_pkg::M3_W-1:0]        e4_m3;
  logic [2:0][31:0]                e4_na;
  logic [2:0][31:0]                e4_nb;
  logic                            e4_moved_a;
  logic                            e4_moved_b;
  logic [75:0]                     dt_prod;

  assign dt_prod = 76'(e3_m2) * 76'(e3_dt);

  always_ff @(posedge clk) begin
    if (rst) e4_v <= 1'b0;
    else if (adv) e4_v <= e3_v;
    if (adv) begin
      e4_u       <= e3_u;
      e4_sneg    <= e3_sneg;
      e4_dneg    <= e3_dneg;
      e4_m3      <= csc_pkg::M3_W'(dt_prod >> csc_pkg::DT_FRAC);
      e4_na      <= e3_na;
      e4_nb      <= e3_nb;
      e4_moved_a <= e3_moved_a;
      e4_moved_b <= e3_moved_b;
    end
  end

  // ---------------------------------------------------------------------------
  // e5: direction products, split into the low 32 bits and the high 28 bits of the magnitude
  // ---------------------------------------------------------------------------
  logic             e5_v;
  logic             e5_sneg;
  logic [2:0]       e5_dneg;
  logic [2:0][62:0] e5_clo;
  logic [2:0][58:0] e5_chi;
  logic [2:0][31:0] e5_na;
  logic [2:0][31:0] e5_nb;
  logic             e5_moved_a;
  logic             e5_moved_b;

  always_ff @(posedge clk) begin
    if (rst) e5_v <= 1'b0;
    else if (adv) e5_v <= e4_v;
    if (adv) begin
      e5_sneg    <= e4_sneg;
      e5_dneg    <= e4_dneg;
      e5_na      <= e4_na;
      e5_nb      <= e4_nb;
      e5_moved_a <= e4_moved_a;
      e5_moved_b <= e4_moved_b;
      for (int i = 0; i < 3; i++) begin
        e5_clo[i] <= 63'(e4_m3[31:0]) * 63'(e4_u[i]);
        e5_chi[i] <= 59'(e4_m3[59:32]) * 59'(e4_u[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register: signed, saturated impulse
  // ---------------------------------------------------------------------------
  logic [2:0][31:0] imp;
  logic [61:0]      mag  [3];
  logic             neg  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = 62'((92'(e5_clo[i]) + (92'(e5_chi[i]) << 32)) >> csc_pkg::UNIT_FRAC);
      neg[i] = e5_sneg != e5_dneg[i];
      if (neg[i]) imp[i] = (mag[i] >= 62'h8000_0000) ? 32'h8000_0000 : 32'(-mag[i]);
      else        imp[i] = (mag[i] > 62'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= e5_v;
    if (adv) begin
      result.impulse_a_x <= imp[0];
      result.impulse_a_y <= imp[1];
      result.impulse_a_z <= imp[2];
      result.new_a_x     <= e5_na[0];
      result.new_a_y     <= e5_na[1];
      result.new_a_z     <= e5_na[2];
      result.new_b_x     <= e5_nb[0];
      result.new_b_y     <= e5_nb[1];
      result.new_b_z     <= e5_nb[2];
      result.moved_a     <= e5_moved_a;
      result.moved_b     <= e5_moved_b;
    end
  end

endmodule

FILE: hw/rtl/csc_checker.sv
// csc_checker: port-level checks on the cloth spring step block
// depends on csc_pkg; bound to cloth_spring_constraint_step below
module csc_checker (
  input logic             clk,
  input logic             rst,
  input logic             spring_ready,
  input logic             result_valid,
  input logic             result_ready,
  input csc_pkg::result_t result
);

  // no item taken while a finished result is held back
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !spring_ready)
    else $error("item accepted while output stalled");

  // an empty output never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> spring_ready)
    else $error("input blocked with empty output");

  // a held result keeps its valid
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped before acceptance");

  // a held result keeps its payload
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(result))
    else $error("result changed while stalled");

endmodule

bind cloth_spring_constraint_step csc_checker u_csc_checker (.*);
